/* hw/rtl/positional_list_store_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the list store unit
// Concurrent checks that vanish in synthesis.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`define POSITIONAL_LIST_STORE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PLS_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
`define PLS_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`else
`define PLS_ASSERT_IMP(label, clk, rst_n, a, c)
`define PLS_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* hw/rtl/pls_pkg.sv */
// ----------------------------------------------------------------------------
// List store package
// Command codes, status codes and sizes shared by the list store files.
// ----------------------------------------------------------------------------
package pls_pkg;
	localparam int unsigned PLS_CAPACITY = 64;
	localparam int unsigned VALUE_W = 32;

	typedef enum logic [2:0] {
		REQ_INS_HEAD = 3'd0,
		REQ_INS_TAIL = 3'd1,
		REQ_INS_POS  = 3'd2,
		REQ_DEL_HEAD = 3'd3,
		REQ_DEL_TAIL = 3'd4,
		REQ_DEL_POS  = 3'd5,
		REQ_READOUT  = 3'd6,
		REQ_NOP      = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_BADPOS = 2'd2,
		ST_FULL   = 2'd3
	} status_t;
endpackage

/* hw/rtl/positional_list_store_unit.sv */
// ----------------------------------------------------------------------------
// Positional list store unit
// Ordered list of signed values kept packed in one RAM; shifts on insert and
// delete, streams the list on read-out.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                  | tuser | tlast
// s_axis  | in  | req_type[2:0] value[34:3] position[42:35]  | -     | -
// m_axis  | out | status[1:0] element[33:2] element_index[39:34] | - | last
//
// A result decided at accept is valid the cycle after accept. Insert and
// delete shift one entry at a time and read-out streams one element at a
// time, all paced by the one RAM read port with registered read data;
// shifting reads ahead one entry.
// Reset clears the count and control only; the RAM needs no clearing.
// A stalled result holds in the output register; no new item while busy.
// ----------------------------------------------------------------------------
module positional_list_store_unit #(
	parameter int unsigned CAPACITY = pls_pkg::PLS_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,  // req_type, value, position
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // status, element, element_index
	output logic        m_axis_tlast
);
	import pls_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SHUP  = 5'b00010,
		S_SHDN  = 5'b00100,
		S_READ  = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    idx_q;
	logic [CW-1:0]    end_q;
	logic [31:0]      val_q;
	logic             rd_pend_q;
	logic             ovalid_q;
	logic [1:0]       ostat_q;
	logic [31:0]      oelem_q;
	logic [5:0]       oidx_q;
	logic             olast_q;

	logic             we;
	logic [AW-1:0]    waddr;
	logic [31:0]      wdata;
	logic [AW-1:0]    raddr;
	logic [31:0]      rdata;

	req_t             req;
	logic [31:0]      in_val;
	logic [7:0]       in_pos;
	logic             acc;
	logic             out_free;

	assign req    = req_t'(s_axis_tdata[2:0]);
	assign in_val = s_axis_tdata[34:3];
	assign in_pos = s_axis_tdata[42:35];
	assign out_free = !ovalid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE) && out_free;
	assign acc = s_axis_tvalid && s_axis_tready;

	pls_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic          full, empty;
	logic [CW:0]   pos_x;
	logic          imm_hit;
	status_t       imm_st;
	logic          shup_done;
	logic          shdn_done;
	logic          o_set;
	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign pos_x = {1'b0, in_pos[CW-1:0]} | ((in_pos >> CW) != 0 ? {1'b1, {CW{1'b0}}} : '0);
	assign shup_done = ((rd_pend_q ? idx_q - 1'b1 : idx_q) == end_q);
	assign shdn_done = ((rd_pend_q ? idx_q + 1'b1 : idx_q) == end_q);

	// commands that answer with a status alone, decided at accept
	always_comb begin
		imm_hit = 1'b0;
		imm_st = ST_OK;
		unique case (req)
			REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
				if (req == REQ_INS_POS && in_pos == '0) begin
					imm_hit = 1'b1;
					imm_st = ST_BADPOS;
				end else if (full) begin
					imm_hit = 1'b1;
					imm_st = ST_FULL;
				end else if (req == REQ_INS_POS && pos_x > {1'b0, count_q} + 1'b1) begin
					imm_hit = 1'b1;
					imm_st = ST_BADPOS;
				end
			end
			REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
				if (empty) begin
					imm_hit = 1'b1;
					imm_st = ST_EMPTY;
				end else if (req == REQ_DEL_POS && (in_pos == '0 ||
						pos_x > {1'b0, count_q})) begin
					imm_hit = 1'b1;
					imm_st = ST_BADPOS;
				end
			end
			REQ_READOUT: begin
				if (empty) begin
					imm_hit = 1'b1;
					imm_st = ST_EMPTY;
				end
			end
			default: ;
		endcase
	end

	assign o_set = (state_q == S_IDLE && acc && imm_hit) ||
		(state_q == S_SHDN && shdn_done) || (state_q == S_OUT) ||
		(state_q == S_READ && rd_pend_q && out_free);

	// shift-up walks idx down from count to slot; shift-down walks up;
	// the read runs one entry ahead of the write
	always_comb begin
		we = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		unique case (state_q)
			S_SHUP: begin
				raddr = rd_pend_q ? AW'(idx_q - 2'd2) : AW'(idx_q - 1'b1);
				if (rd_pend_q) begin
					we = 1'b1;
					waddr = AW'(idx_q);
				end
			end
			S_SHDN: begin
				raddr = rd_pend_q ? AW'(idx_q + 2'd2) : AW'(idx_q + 1'b1);
				if (rd_pend_q) begin
					we = 1'b1;
					waddr = AW'(idx_q);
				end
			end
			S_OUT: begin
				we = 1'b1;
				waddr = AW'(end_q);
				wdata = val_q;
			end
			S_READ: raddr = AW'(idx_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovalid_q <= 1'b0;
			rd_pend_q <= 1'b0;
			idx_q <= '0;
			end_q <= '0;
		end else begin
			ovalid_q <= o_set || (ovalid_q && !m_axis_tready);
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						ostat_q <= imm_st;
						oelem_q <= '0;
						oidx_q <= '0;
						olast_q <= 1'b1;
						val_q <= in_val;
						rd_pend_q <= 1'b0;
						if (!imm_hit) begin
							unique case (req)
								REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
									idx_q <= count_q;
									if (req == REQ_INS_HEAD) end_q <= '0;
									else if (req == REQ_INS_TAIL) end_q <= count_q;
									else end_q <= CW'(in_pos - 8'd1);
									state_q <= S_SHUP;
								end
								REQ_DEL_HEAD, REQ_DEL_TAIL, REQ_DEL_POS: begin
									if (req == REQ_DEL_HEAD) idx_q <= '0;
									else if (req == REQ_DEL_TAIL) idx_q <= count_q - 1'b1;
									else idx_q <= CW'(in_pos - 8'd1);
									end_q <= count_q - 1'b1;
									state_q <= S_SHDN;
								end
								REQ_READOUT: begin
									idx_q <= '0;
									state_q <= S_READ;
								end
								default: ;
							endcase
						end
					end
				end
				S_SHUP: begin
					// write the entry read last cycle one slot up
					if (rd_pend_q)
						idx_q <= idx_q - 1'b1;
					if (shup_done) begin
						state_q <= S_OUT;
						rd_pend_q <= 1'b0;
					end else
						rd_pend_q <= 1'b1;
				end
				S_SHDN: begin
					if (rd_pend_q)
						idx_q <= idx_q + 1'b1;
					if (shdn_done) begin
						count_q <= count_q - 1'b1;
						state_q <= S_IDLE;
						rd_pend_q <= 1'b0;
					end else
						rd_pend_q <= 1'b1;
				end
				S_OUT: begin
					count_q <= count_q + 1'b1;
					state_q <= S_IDLE;
				end
				S_READ: begin
					// rd_pend marks that read data for the entry at idx is ready
					if (rd_pend_q) begin
						if (out_free) begin
							oelem_q <= rdata;
							oidx_q <= 6'(idx_q);
							olast_q <= (idx_q + 1'b1 == count_q);
							ostat_q <= ST_OK;
							rd_pend_q <= 1'b0;
							if (idx_q + 1'b1 == count_q)
								state_q <= S_IDLE;
							else
								idx_q <= idx_q + 1'b1;
						end
					end else
						rd_pend_q <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {oidx_q, oelem_q, ostat_q};
	assign m_axis_tlast  = olast_q;

`include "positional_list_store_unit_assert.svh"
	`PLS_ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`PLS_ASSERT_IMP(a_busy_no_acc, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
	`PLS_ASSERT_NXT(a_ins_grow, clk, arst_n, state_q == S_OUT, count_q == $past(count_q) + 1'b1)
	`PLS_ASSERT_IMP(a_read_nonempty, clk, arst_n, state_q == S_READ, count_q != '0)
endmodule

/* hw/rtl/pls_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pls_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
